@@ rtl/assert_macros.svh @@
// assertion macros used by bounded_deque, the rtl file that checks itself
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is held
`define BDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define BDQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bdq_pkg.sv @@
// shared types, codes and helpers for the bounded deque
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int ADDR_W = 3;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(10);

  localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [1:0] CMD_PUSH_REAR  = 2'd1;
  localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [1:0] CMD_POP_REAR   = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // register index held in paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] order_id;
    logic [7:0]  order_age;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [15:0]      popped_id;
    logic [7:0]       popped_age;
    logic [CNT_W-1:0] occupancy;
  } out_word_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  age;
  } rec_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

  // circular position, base below DEPTH and offset at most DEPTH
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] offset);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(offset);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/bdq_regs.sv @@
// configuration register block: capacity behind an apb-style port
// depends on bdq_pkg
`timescale 1ns / 1ps
`default_nettype none

module bdq_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [bdq_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output logic      [bdq_pkg::CNT_W-1:0] capacity
);

  logic [bdq_pkg::CNT_W-1:0] capacity_r;
  logic                      wr_en;

  assign pready   = 1'b1;
  assign wr_en    = psel & penable & pwrite & pready & (paddr[2] == bdq_pkg::REG_CAPACITY);
  assign capacity = capacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= bdq_pkg::CAP_RESET;
    end else if (wr_en) begin
      capacity_r <= pwdata[bdq_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == bdq_pkg::REG_CAPACITY) begin
      prdata = 32'(capacity_r);
    end
  end

endmodule

`default_nettype wire

@@ rtl/bdq_ctrl.sv @@
// command sequencer: accept, execute, respond
// depends on bdq_pkg
`timescale 1ns / 1ps
`default_nettype none

module bdq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  output logic               out_valid,
  output bdq_pkg::ctl_t      ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state_r;
  logic   busy_r;
  logic   exec_r;
  logic   valid_r;

  assign busy      = busy_r;
  assign out_valid = valid_r;
  assign ctl.load  = start & ~busy_r;
  assign ctl.exec  = exec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      exec_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_EXEC;
            busy_r  <= 1'b1;
            exec_r  <= 1'b1;
          end
        end
        S_EXEC: begin
          state_r <= S_RESP;
          exec_r  <= 1'b0;
          valid_r <= 1'b1;
        end
        S_RESP: begin
          state_r <= S_IDLE;
          valid_r <= 1'b0;
          busy_r  <= 1'b0;
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
          exec_r  <= 1'b0;
          valid_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/bdq_datapath.sv @@
// deque datapath: circular record store, head pointer and count
// depends on bdq_pkg
`timescale 1ns / 1ps
`default_nettype none

module bdq_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire bdq_pkg::ctl_t             ctl,
  input  wire bdq_pkg::in_word_t         in_data,
  input  wire logic [bdq_pkg::CNT_W-1:0] capacity,
  output bdq_pkg::out_word_t             out_data
);

  localparam int IDX_W = bdq_pkg::IDX_W;
  localparam int CNT_W = bdq_pkg::CNT_W;

  bdq_pkg::rec_t     mem [bdq_pkg::DEPTH];
  bdq_pkg::in_word_t item_r;
  bdq_pkg::rec_t     rd_data_r;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              has_data_r;
  logic [CNT_W-1:0]  limit;
  logic [IDX_W-1:0]  pos;
  logic              wr_en, rd_en;

  always_comb begin
    limit = (capacity > CNT_W'(bdq_pkg::DEPTH)) ? CNT_W'(bdq_pkg::DEPTH) : capacity;
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = bdq_pkg::ST_DONE;
    pos        = head_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    case (item_r.command)
      bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_REAR: begin
        if (count_r >= limit) begin
          status_nxt = bdq_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          if (item_r.command == bdq_pkg::CMD_PUSH_FRONT) begin
            pos      = bdq_pkg::wrap_add(head_r, CNT_W'(bdq_pkg::DEPTH - 1));
            head_nxt = pos;
          end else begin
            pos = bdq_pkg::wrap_add(head_r, count_r);
          end
        end
      end
      bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_REAR: begin
        if (count_r == '0) begin
          status_nxt = bdq_pkg::ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          count_nxt = count_r - CNT_W'(1);
          if (item_r.command == bdq_pkg::CMD_POP_FRONT) begin
            pos      = head_r;
            head_nxt = bdq_pkg::wrap_add(head_r, CNT_W'(1));
          end else begin
            pos = bdq_pkg::wrap_add(head_r, count_r - CNT_W'(1));
          end
        end
      end
      default: begin
        status_nxt = bdq_pkg::ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (ctl.exec) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= in_data;
    end
    if (ctl.exec) begin
      status_r   <= status_nxt;
      has_data_r <= rd_en;
    end
  end

  // record store, registered read
  always_ff @(posedge clk) begin
    if (ctl.exec && wr_en) begin
      mem[pos] <= '{id: item_r.order_id, age: item_r.order_age};
    end
    if (ctl.exec && rd_en) begin
      rd_data_r <= mem[pos];
    end
  end

  assign out_data.status     = status_r;
  assign out_data.popped_id  = has_data_r ? rd_data_r.id : 16'd0;
  assign out_data.popped_age = has_data_r ? rd_data_r.age : 8'd0;
  assign out_data.occupancy  = count_r;

endmodule

`default_nettype wire

@@ rtl/bounded_deque.sv @@
// top level of the bounded double-ended queue of id/age records
// depends on bdq_pkg, bdq_regs, bdq_ctrl, bdq_datapath and assert_macros.svh
//
// usage:
//   input: drive in_data and raise start; the word is taken at the edge where
//   start is high and busy is low. commands are push front, push rear,
//   pop front and pop rear.
//   output: each command gives one result word on out_data, marked by
//   out_valid for exactly one cycle, once the sequencer's execute step is done.
//   the result holds status, the removed record (zero for pushes and empty
//   pops) and the occupancy after the command.
//   the sequencer takes no new command until its accept, execute and respond
//   steps for the last one are through, around the store's registered read.
//   capacity is written through the apb-style port at address 0 while idle;
//   it reads back the stored value, and values above the store depth act as
//   the depth.
//   reset: synchronous, active low; the queue comes up empty with capacity 10.
//   the receiver cannot stall and must take each result as it appears.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bounded_deque (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire bdq_pkg::in_word_t          in_data,
  output logic                            out_valid,
  output bdq_pkg::out_word_t              out_data,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [bdq_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);

  bdq_pkg::ctl_t             ctl;
  logic [bdq_pkg::CNT_W-1:0] capacity;

  bdq_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  bdq_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_data  (in_data),
    .capacity (capacity),
    .out_data (out_data)
  );

  `BDQ_ASSERT(a_accept_to_result, clk, rst_n, ctl.load |=> ##1 out_valid, "no result after accept")
  `BDQ_ASSERT(a_result_while_busy, clk, rst_n, out_valid |-> busy, "result outside busy window")
  `BDQ_ASSERT(a_occ_bound, clk, rst_n, out_valid |-> (out_data.occupancy <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH)), "occupancy above depth")
  `BDQ_ASSERT(a_no_data_on_fail, clk, rst_n, (out_valid && out_data.status != bdq_pkg::ST_DONE) |-> (out_data.popped_id == 16'd0 && out_data.popped_age == 8'd0), "record on refused command")
  `BDQ_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (!busy && !out_valid), "not idle after reset")

endmodule

`default_nettype wire
